/* rtl/tccs_pkg.sv */
// Shared types and constants for the text console cursor and scroll block.
package tccs_pkg;

    // Default store geometry
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;

    // Widths of store coordinates across the whole parameter range
    localparam int ROW_W = 7;
    localparam int COL_W = 8;

    // Character codes
    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    // Tab stop spacing (power of two)
    localparam logic [7:0] TAB_STOP = 8'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_INDEX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BG_INDEX = 2'd3;

    // Reset values
    localparam logic [7:0]  RST_COLUMNS  = 8'd80;
    localparam logic [6:0]  RST_ROWS     = 7'd25;
    localparam logic [7:0]  RST_FG_INDEX = 8'd7;
    localparam logic [7:0]  RST_BG_INDEX = 8'd0;
    localparam logic [15:0] ATTR_RESET   = 16'h0007;

    // Request to the remainder unit
    typedef struct packed {
        logic       start;
        logic [7:0] a;
        logic [7:0] b;
    } mod_req_t;

    // Response from the remainder unit
    typedef struct packed {
        logic       done;
        logic [7:0] rem;
    } mod_rsp_t;

    // Write request to the cell store
    typedef struct packed {
        logic             cwe;
        logic             awe;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       cdata;
        logic [15:0]      adata;
    } store_wr_t;

endpackage

/* rtl/tccs_mod.sv */
// Iterative restoring remainder unit, one quotient bit per cycle.
module tccs_mod
    import tccs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [2:0]  step_reg;
    logic [7:0]  rem_reg;
    logic [14:0] dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd7;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 3'd1;
                if (step_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Subtract the shifted divisor wherever it fits
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.a;
            dsh_reg <= {req.b, 7'd0};
        end
        else if (busy_reg)
        begin
            if ({7'd0, rem_reg} >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg[7:0];
            end
            dsh_reg <= {1'b0, dsh_reg[14:1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

/* rtl/tccs_store.sv */
// Character and attribute cell memories with the clearing pass after reset.
module tccs_store
    import tccs_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  store_wr_t wr,
    output logic      clearing
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]    char_mem [DEPTH];
    logic [15:0]   attr_mem [DEPTH];

    logic          clr_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] addr;
    logic          in_range;

    assign in_range = (int'(wr.row) < MAX_ROWS) && (int'(wr.col) < MAX_COLS);
    assign addr     = AW'(int'(wr.row) * MAX_COLS + int'(wr.col));

    // Sweep every entry once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (clr_reg)
        begin
            idx_reg <= idx_reg + AW'(1);
            if (idx_reg == AW'(DEPTH - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            char_mem[idx_reg] <= 8'd0;
            attr_mem[idx_reg] <= ATTR_RESET;
        end
        else
        begin
            if (wr.cwe && in_range)
            begin
                char_mem[addr] <= wr.cdata;
            end
            if (wr.awe && in_range)
            begin
                attr_mem[addr] <= wr.adata;
            end
        end
    end

    assign clearing = clr_reg;

endmodule

/* rtl/text_console_cursor_scroll.sv */
// Top level of the text console cursor and scroll block.
//
// Usage: one character byte per input beat on in_valid/in_ready/char_code.
// Each accepted byte yields exactly one result beat on out_valid/out_ready:
// the cell write (if a printable byte was stored), the scroll notice, the
// first shown store row and the cursor after the byte.
// Configuration beats (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
// column and row counts and the foreground/background indexes; cfg_ready is
// always high and writes are meant only while the block is idle.
// Timing: an accepted byte goes into the working registers, is evaluated,
// and its result is then registered in the output register. A row index or
// column wrap that does not fit one subtract goes through the 8-step
// remainder unit. A scroll runs the remainder unit once and then zeroes
// the characters of the oldest row one cell per cycle.
// Reset: cursor and first row go to zero, registers to their defaults, and
// the cell store is swept, one entry per cycle, over all MAX_ROWS * MAX_COLS
// entries (8192 by default); in_ready stays low during the sweep.
// Stall: a finished result waits in the output register; a following byte is
// still accepted and held until the output register frees up.
module text_console_cursor_scroll
    import tccs_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           char_code,
    // output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 cell_written,
    output logic [5:0]           cell_row,
    output logic [6:0]           cell_col,
    output logic [7:0]           cell_char,
    output logic [15:0]          cell_attr,
    output logic                 scrolled,
    output logic [5:0]           cleared_row,
    output logic [5:0]           first_row,
    output logic [6:0]           cursor_col,
    output logic [5:0]           cursor_row
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PMOD = 3'd1;  // wait for physical row remainder
    localparam logic [2:0] S_EVAL = 3'd2;  // store the cell, wrap, check scroll
    localparam logic [2:0] S_XMOD = 3'd3;  // wait for column remainder
    localparam logic [2:0] S_SMOD = 3'd4;  // wait for oldest row remainder
    localparam logic [2:0] S_CLR  = 3'd5;  // zero the oldest row
    localparam logic [2:0] S_DONE = 3'd6;  // hand the result to the output

    // Configuration
    logic [7:0]  columns_reg;
    logic [6:0]  rows_reg;
    logic [7:0]  fg_reg;
    logic [7:0]  bg_reg;

    // Architectural state
    logic [6:0]  cursor_x_reg;
    logic [5:0]  cursor_y_reg;
    logic [6:0]  top_reg;

    // Working registers for the item in flight
    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic        written_reg;
    logic [7:0]  char_reg;
    logic [15:0] attr_reg;
    logic [6:0]  wcol_reg;
    logic [6:0]  phys_reg;
    logic [7:0]  x_reg;
    logic [6:0]  y_reg;
    logic [6:0]  top_new_reg;
    logic        scrolled_reg;
    logic [6:0]  cleared_reg;
    logic [7:0]  k_reg;

    // Output register
    logic        out_valid_reg;
    logic        cell_written_reg;
    logic [5:0]  cell_row_reg;
    logic [6:0]  cell_col_reg;
    logic [7:0]  cell_char_reg;
    logic [15:0] cell_attr_reg;
    logic        scrolled_out_reg;
    logic [5:0]  cleared_row_reg;
    logic [5:0]  first_row_reg;
    logic [6:0]  cursor_col_reg;
    logic [5:0]  cursor_row_reg;

    // Submodule links
    mod_req_t    mreq;
    mod_rsp_t    mrsp;
    store_wr_t   swr;
    logic        clearing;

    // Effective sizes
    logic [7:0]  cols_eff;
    logic [6:0]  rows_eff;

    // Accept-time values
    logic        in_acc;
    logic        printable;
    logic [7:0]  sum_a;
    logic [7:0]  sum_sub;
    logic        phys_ok;
    logic [7:0]  phys_fast;
    logic [7:0]  x_in;
    logic [7:0]  tab_sum;
    logic [7:0]  x1;
    logic [6:0]  y1;

    // Evaluation-time values
    logic        wrap;
    logic [7:0]  xd;
    logic        x_fast_ok;
    logic [7:0]  x2;
    logic [6:0]  y2;
    logic        need_scroll;
    logic        out_free;
    logic        load;
    logic [7:0]  fin_x;
    logic [6:0]  fin_y;
    logic [7:0]  rem_inc;

    assign cols_eff = (columns_reg == 8'd0) ? 8'd1 :
                      (int'(columns_reg) > MAX_COLS) ? 8'(MAX_COLS) : columns_reg;
    assign rows_eff = (rows_reg == 7'd0) ? 7'd1 :
                      (int'(rows_reg) > MAX_ROWS) ? 7'(MAX_ROWS) : rows_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !clearing;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Decode the byte against the current cursor
    assign printable = (char_code != CH_NUL) && (char_code != CH_TAB) &&
                       (char_code != CH_CR) && (char_code != CH_LF);
    assign sum_a     = {1'b0, top_reg} + {2'b00, cursor_y_reg};
    assign sum_sub   = sum_a - {1'b0, rows_eff};
    assign phys_ok   = (sum_a < {1'b0, rows_eff}) || (sum_sub < {1'b0, rows_eff});
    assign phys_fast = (sum_a < {1'b0, rows_eff}) ? sum_a : sum_sub;
    assign x_in      = {1'b0, cursor_x_reg};
    assign tab_sum   = x_in + TAB_STOP;

    always_comb
    begin
        x1 = x_in;
        y1 = {1'b0, cursor_y_reg};
        case (char_code)
            CH_NUL:
            begin
                x1 = x_in;
            end
            CH_TAB:
            begin
                x1 = {tab_sum[7:2], 2'b00};
            end
            CH_CR:
            begin
                x1 = 8'd0;
            end
            CH_LF:
            begin
                x1 = 8'd0;
                y1 = {1'b0, cursor_y_reg} + 7'd1;
            end
            default:
            begin
                x1 = x_in + 8'd1;
            end
        endcase
    end

    // Column wrap, fast when a single subtract brings it in range
    assign wrap      = x_reg >= cols_eff;
    assign xd        = x_reg - cols_eff;
    assign x_fast_ok = !wrap || (xd < cols_eff);
    assign x2        = wrap ? xd : x_reg;
    assign y2        = y_reg + {6'd0, wrap};
    assign need_scroll = (state_reg == S_XMOD) ? (y_reg >= rows_eff) : (y2 >= rows_eff);
    assign rem_inc   = mrsp.rem + 8'd1;

    // Result goes out directly from evaluation when nothing else is pending, else from S_DONE
    always_comb
    begin
        load  = 1'b0;
        fin_x = x_reg;
        fin_y = y_reg;
        case (state_reg)
            S_EVAL:
            begin
                fin_x = x2;
                fin_y = y2;
                load  = x_fast_ok && !need_scroll && out_free;
            end
            S_DONE:
            begin
                load = out_free;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    // Sequencer and remainder requests
    always_comb
    begin
        state_next = state_reg;
        mreq.start = 1'b0;
        mreq.a     = sum_a;
        mreq.b     = {1'b0, rows_eff};
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (char_code == CH_NUL)
                    begin
                        state_next = S_DONE;
                    end
                    else if (printable && !phys_ok)
                    begin
                        mreq.start = 1'b1;
                        state_next = S_PMOD;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_PMOD:
            begin
                if (mrsp.done)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!x_fast_ok)
                begin
                    mreq.start = 1'b1;
                    mreq.a     = x_reg;
                    mreq.b     = cols_eff;
                    state_next = S_XMOD;
                end
                else if (need_scroll)
                begin
                    mreq.start = 1'b1;
                    mreq.a     = {1'b0, top_reg};
                    state_next = S_SMOD;
                end
                else if (load)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_XMOD:
            begin
                if (mrsp.done)
                begin
                    if (need_scroll)
                    begin
                        mreq.start = 1'b1;
                        mreq.a     = {1'b0, top_reg};
                        state_next = S_SMOD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SMOD:
            begin
                if (mrsp.done)
                begin
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                if (k_reg == cols_eff - 8'd1)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Store writes: the cell in evaluation, zero characters while clearing a row
    always_comb
    begin
        swr.cwe   = 1'b0;
        swr.awe   = 1'b0;
        swr.row   = phys_reg;
        swr.col   = {1'b0, wcol_reg};
        swr.cdata = char_reg;
        swr.adata = attr_reg;
        case (state_reg)
            S_EVAL:
            begin
                swr.cwe = written_reg && (int'(wcol_reg) < MAX_COLS);
                swr.awe = written_reg && (int'(wcol_reg) < MAX_COLS);
            end
            S_CLR:
            begin
                swr.cwe   = 1'b1;
                swr.row   = cleared_reg;
                swr.col   = k_reg;
                swr.cdata = 8'd0;
            end
            default:
            begin
                swr.cwe = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            columns_reg   <= RST_COLUMNS;
            rows_reg      <= RST_ROWS;
            fg_reg        <= RST_FG_INDEX;
            bg_reg        <= RST_BG_INDEX;
            cursor_x_reg  <= 7'd0;
            cursor_y_reg  <= 6'd0;
            top_reg       <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_COLUMNS:  columns_reg <= cfg_data;
                    REG_ROWS:     rows_reg    <= cfg_data[6:0];
                    REG_FG_INDEX: fg_reg      <= cfg_data;
                    REG_BG_INDEX: bg_reg      <= cfg_data;
                    default:      fg_reg      <= fg_reg;
                endcase
            end
            // Commit the cursor and first row with the result
            if (load)
            begin
                out_valid_reg <= 1'b1;
                cursor_x_reg  <= fin_x[6:0];
                cursor_y_reg  <= fin_y[5:0];
                top_reg       <= top_new_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the item in flight
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    written_reg  <= printable;
                    char_reg     <= char_code;
                    attr_reg     <= {bg_reg, fg_reg};
                    wcol_reg     <= cursor_x_reg;
                    phys_reg     <= phys_fast[6:0];
                    x_reg        <= x1;
                    y_reg        <= y1;
                    top_new_reg  <= top_reg;
                    scrolled_reg <= 1'b0;
                    cleared_reg  <= 7'd0;
                end
            end
            S_PMOD:
            begin
                if (mrsp.done)
                begin
                    phys_reg <= mrsp.rem[6:0];
                end
            end
            S_EVAL:
            begin
                y_reg <= y2;
                if (x_fast_ok)
                begin
                    x_reg <= x2;
                end
            end
            S_XMOD:
            begin
                if (mrsp.done)
                begin
                    x_reg <= mrsp.rem;
                end
            end
            S_SMOD:
            begin
                if (mrsp.done)
                begin
                    cleared_reg  <= mrsp.rem[6:0];
                    top_new_reg  <= (rem_inc == {1'b0, rows_eff}) ? 7'd0 : rem_inc[6:0];
                    y_reg        <= rows_eff - 7'd1;
                    scrolled_reg <= 1'b1;
                    k_reg        <= 8'd0;
                end
            end
            S_CLR:
            begin
                k_reg <= k_reg + 8'd1;
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    // Output register payload; unused fields read as zero
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cell_written_reg <= written_reg;
            cell_row_reg     <= written_reg ? phys_reg[5:0] : 6'd0;
            cell_col_reg     <= written_reg ? wcol_reg : 7'd0;
            cell_char_reg    <= written_reg ? char_reg : 8'd0;
            cell_attr_reg    <= written_reg ? attr_reg : 16'd0;
            scrolled_out_reg <= scrolled_reg;
            cleared_row_reg  <= scrolled_reg ? cleared_reg[5:0] : 6'd0;
            first_row_reg    <= top_new_reg[5:0];
            cursor_col_reg   <= fin_x[6:0];
            cursor_row_reg   <= fin_y[5:0];
        end
    end

    tccs_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    tccs_store #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (swr),
        .clearing (clearing)
    );

    assign out_valid    = out_valid_reg;
    assign cell_written = cell_written_reg;
    assign cell_row     = cell_row_reg;
    assign cell_col     = cell_col_reg;
    assign cell_char    = cell_char_reg;
    assign cell_attr    = cell_attr_reg;
    assign scrolled     = scrolled_out_reg;
    assign cleared_row  = cleared_row_reg;
    assign first_row    = first_row_reg;
    assign cursor_col   = cursor_col_reg;
    assign cursor_row   = cursor_row_reg;

endmodule
